FILE: src/ppo_pkg.sv
// Shared constants for the orthographic point projection block.
`default_nettype none
package ppo_pkg;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 63;
    localparam int SCREEN_W    = 28;
    localparam int DEPTH_W     = 32;
    localparam int SLOT_W      = 21;
    localparam int SCALE_W     = 24;
    localparam int NORM_BITS   = 30;
    localparam int SQRT_STEPS  = 31;
    localparam int DDIV_STEPS  = 32;
    localparam int SDIV_STEPS  = 25;
    localparam int OUT_DATA_W  = 96;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH   = 3'd6;
endpackage
`default_nettype wire

FILE: src/project_point_orthographic_top.sv
// Orthographic point projection: affine transform, normalize, scale, depth.
//
// Input stream: one 3D point per request on i_s_axis_*, accepted when tvalid and
// tready are both high. Output stream: one result per point on o_m_axis_*, in
// the same order. Configuration: i_cfg_valid/o_cfg_ready with a register index
// and data; ready is always high, write only while no point is in flight.
// Throughput is one point per cycle while the receiver accepts: every step is its
// own register stage, so a new point enters each cycle unless the output stalls.
// The path from input to o_m_axis_tvalid runs through nine front stages, the 31
// square root stages, one length stage, the 25 screen divide stages and the output
// register; the depth divide runs alongside the square root and length stages.
// When the receiver stalls, the whole pipeline holds and o_s_axis_tready drops;
// nothing is lost or repeated. Reset clears all valid bits and loads the
// register defaults: identity rotation, zero translation, scale 256.0,
// centre 0, near 0.0 and far 1.0.
// Degenerate points (zero transformed vector or far equal to near) give zero
// screen and depth fields with the degenerate flag set.
`default_nettype none
module project_point_orthographic_top #(
    parameter int POS_WIDTH  = 21,
    parameter int COEF_WIDTH = 21
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // tdata: point_x, point_y, point_z (from bit 0 up), zero padded
    input  wire logic [((3*POS_WIDTH+7)/8)*8-1:0]   i_s_axis_tdata,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // tdata: screen_x, screen_y, depth, in_front, degenerate (from bit 0 up)
    output logic [ppo_pkg::OUT_DATA_W-1:0]          o_m_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [ppo_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [ppo_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    localparam int SW_ = ppo_pkg::SLOT_W;
    localparam int PW  = POS_WIDTH + COEF_WIDTH;
    localparam int SMW = PW + 2;
    localparam int F   = COEF_WIDTH - 2;
    localparam int TW  = ((SMW - F) > SW_ ? (SMW - F) : SW_) + 1;
    localparam int MW  = TW;
    localparam int AW  = (MW > ppo_pkg::NORM_BITS) ? MW : ppo_pkg::NORM_BITS;
    localparam int KW  = $clog2(MW + 1);
    localparam int NW  = TW + 1;
    localparam int DW  = SW_ + 1;
    localparam int DRW = ((NW + 18) > (DW + 1 + ppo_pkg::DDIV_STEPS) ?
                          (NW + 18) : (DW + 1 + ppo_pkg::DDIV_STEPS)) + 1;
    localparam int XRW = 57;
    localparam int PXW = ppo_pkg::NORM_BITS + ppo_pkg::SCALE_W;
    localparam int L   = ppo_pkg::SQRT_STEPS + 1 + ppo_pkg::SDIV_STEPS;

    typedef struct packed {
        logic           deg;
        logic           neg_x;
        logic           neg_y;
        logic           dneg;
        logic           dovf;
        logic [DW:0]    dden;
        logic [DRW-1:0] drem;
    } t_dep;

    typedef struct packed {
        t_dep           dep;
        logic [31:0]    dq;
        logic [61:0]    sq_n;
        logic [61:0]    sq_r;
        logic [PXW-1:0] px;
        logic [PXW-1:0] py;
        logic [30:0]    len;
        logic [XRW-1:0] xrem;
        logic [XRW-1:0] yrem;
        logic [24:0]    qx;
        logic [24:0]    qy;
    } t_lane;

    // configuration
    logic [62:0] r_row [3];
    logic [62:0] r_trans;
    logic [23:0] r_scale;
    logic [33:0] r_centre;
    logic [41:0] r_planes;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= 63'd524288;
            r_row[1] <= 63'd1099511627776;
            r_row[2] <= 63'd2305843009213693952;
            r_trans  <= '0;
            r_scale  <= 24'd65536;
            r_centre <= '0;
            r_planes <= 42'd8589934592;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ppo_pkg::CFG_ROW_X:  r_row[0] <= i_cfg_data;
                ppo_pkg::CFG_ROW_Y:  r_row[1] <= i_cfg_data;
                ppo_pkg::CFG_ROW_Z:  r_row[2] <= i_cfg_data;
                ppo_pkg::CFG_TRANS:  r_trans  <= i_cfg_data;
                ppo_pkg::CFG_SCALE:  r_scale  <= i_cfg_data[23:0];
                ppo_pkg::CFG_CENTRE: r_centre <= i_cfg_data[33:0];
                ppo_pkg::CFG_DEPTH:  r_planes <= i_cfg_data[41:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic r_ov;
    assign en = !r_ov || i_m_axis_tready;
    assign o_s_axis_tready = en;

    logic signed [SW_-1:0] near_v, far_v;
    assign near_v = $signed(r_planes[20:0]);
    assign far_v  = $signed(r_planes[41:21]);

    // front stages
    logic                        r0_v, r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v;
    logic signed [POS_WIDTH-1:0] r0_p [3];
    logic signed [PW-1:0]        r1_prod [3][3];
    logic signed [SMW-1:0]       r2_sum [3];
    logic signed [TW-1:0]        r3_t [3];
    logic [MW-1:0]               r4_a [3];
    logic                        r4_nx, r4_ny, r4_deg;
    logic signed [NW-1:0]        r4_num;
    logic signed [DW-1:0]        r4_den;
    logic [MW-1:0]               r5_a [3];
    logic [KW-1:0]               r5_k;
    t_dep                        r5_dep, r6_dep, r7_dep;
    logic [ppo_pkg::NORM_BITS-1:0] r6_a [3];
    logic [59:0]                 r7_sq [3];
    logic [PXW-1:0]              r7_px, r7_py;
    t_lane                       r8_lane;
    t_lane                       r_pipe [L];
    logic [L-1:0]                r_pv;
    t_lane                       n_pipe [L];

    logic signed [SMW-1:0] n2_sum [3];
    logic signed [TW-1:0]  n3_t [3];
    logic [MW-1:0]         n4_a [3];
    logic [KW-1:0]         n5_k;
    t_dep                  n5_dep;
    logic [ppo_pkg::NORM_BITS-1:0] n6_a [3];

    always_comb begin
        logic signed [SMW-1:0] s;
        for (int r = 0; r < 3; r++) begin
            s = SMW'(r1_prod[r][0]) + SMW'(r1_prod[r][1]) + SMW'(r1_prod[r][2]);
            n2_sum[r] = s + (SMW'(1) <<< (F - 1));
            n3_t[r] = TW'(r2_sum[r] >>> F) + TW'($signed(r_trans[SW_*r +: SW_]));
            n4_a[r] = r3_t[r][TW-1] ? MW'(-r3_t[r]) : MW'(r3_t[r]);
        end
    end

    // shift count from the highest set bit of the magnitudes
    always_comb begin
        logic [MW-1:0] o;
        o = r4_a[0] | r4_a[1] | r4_a[2];
        n5_k = '0;
        for (int b = ppo_pkg::NORM_BITS; b < MW; b++) begin
            if (o[b]) n5_k = KW'(b - ppo_pkg::NORM_BITS + 1);
        end
    end

    always_comb begin
        logic [NW-1:0]  nmag;
        logic [DW-1:0]  dmag;
        logic [DRW-1:0] nn;
        nmag = r4_num[NW-1] ? NW'(-r4_num) : NW'(r4_num);
        dmag = r4_den[DW-1] ? DW'(-r4_den) : DW'(r4_den);
        nn = (DRW'(nmag) << 17) + DRW'(dmag);
        n5_dep.deg   = r4_deg;
        n5_dep.neg_x = r4_nx;
        n5_dep.neg_y = r4_ny;
        n5_dep.dneg  = r4_num[NW-1] != r4_den[DW-1];
        n5_dep.dden  = {dmag, 1'b0};
        n5_dep.drem  = nn;
        n5_dep.dovf  = nn >= (DRW'({dmag, 1'b0}) << ppo_pkg::DDIV_STEPS);
    end

    always_comb begin
        logic [AW-1:0] e;
        for (int r = 0; r < 3; r++) begin
            e = AW'(r5_a[r]) >> r5_k;
            n6_a[r] = e[ppo_pkg::NORM_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_p[0] <= $signed(i_s_axis_tdata[POS_WIDTH-1:0]);
            r0_p[1] <= $signed(i_s_axis_tdata[2*POS_WIDTH-1:POS_WIDTH]);
            r0_p[2] <= $signed(i_s_axis_tdata[3*POS_WIDTH-1:2*POS_WIDTH]);
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r1_prod[r][c] <= PW'(r0_p[c]) *
                        PW'($signed(r_row[r][SW_*c +: COEF_WIDTH]));
                end
            end
            r2_sum <= n2_sum;
            r3_t   <= n3_t;
            r4_a   <= n4_a;
            r4_nx  <= r3_t[0][TW-1];
            r4_ny  <= r3_t[1][TW-1];
            r4_deg <= ((r3_t[0] == '0) && (r3_t[1] == '0) && (r3_t[2] == '0)) ||
                      (far_v == near_v);
            r4_num <= -NW'(r3_t[2]) - NW'(near_v);
            r4_den <= DW'(far_v) - DW'(near_v);
            r5_a   <= r4_a;
            r5_k   <= n5_k;
            r5_dep <= n5_dep;
            r6_a   <= n6_a;
            r6_dep <= r5_dep;
            for (int r = 0; r < 3; r++) begin
                r7_sq[r] <= 60'(r6_a[r]) * 60'(r6_a[r]);
            end
            r7_px  <= PXW'(r6_a[0]) * PXW'(r_scale);
            r7_py  <= PXW'(r6_a[1]) * PXW'(r_scale);
            r7_dep <= r6_dep;
            r8_lane.dep  <= r7_dep;
            r8_lane.dq   <= '0;
            r8_lane.sq_n <= 62'(r7_sq[0]) + 62'(r7_sq[1]) + 62'(r7_sq[2]);
            r8_lane.sq_r <= '0;
            r8_lane.px   <= r7_px;
            r8_lane.py   <= r7_py;
            r8_lane.len  <= '0;
            r8_lane.xrem <= '0;
            r8_lane.yrem <= '0;
            r8_lane.qx   <= '0;
            r8_lane.qy   <= '0;
            r_pipe <= n_pipe;
        end
    end

    // square root, depth divide and screen divide, one step per stage
    always_comb begin
        t_lane          cur;
        logic [61:0]    bitv, trial;
        logic [DRW-1:0] dt;
        logic [XRW-1:0] st;
        for (int j = 0; j < L; j++) begin
            cur = (j == 0) ? r8_lane : r_pipe[(j == 0) ? 0 : j - 1];
            if (j < ppo_pkg::SQRT_STEPS) begin
                bitv  = 62'(1) << (2 * (ppo_pkg::SQRT_STEPS - 1 - j));
                trial = cur.sq_r + bitv;
                if (cur.sq_n >= trial) begin
                    cur.sq_n = cur.sq_n - trial;
                    cur.sq_r = (cur.sq_r >> 1) + bitv;
                end else begin
                    cur.sq_r = cur.sq_r >> 1;
                end
            end
            if (j < ppo_pkg::DDIV_STEPS) begin
                dt = DRW'(cur.dep.dden) << (ppo_pkg::DDIV_STEPS - 1 - j);
                if (cur.dep.drem >= dt) begin
                    cur.dep.drem = cur.dep.drem - dt;
                    cur.dq[ppo_pkg::DDIV_STEPS - 1 - j] = 1'b1;
                end
            end
            if (j == ppo_pkg::SQRT_STEPS) begin
                cur.len  = cur.sq_r[30:0];
                cur.xrem = (XRW'(cur.px) << 1) + XRW'(cur.sq_r[30:0]);
                cur.yrem = (XRW'(cur.py) << 1) + XRW'(cur.sq_r[30:0]);
            end
            if (j > ppo_pkg::SQRT_STEPS) begin
                st = XRW'({cur.len, 1'b0}) << (L - 1 - j);
                if (cur.xrem >= st) begin
                    cur.xrem = cur.xrem - st;
                    cur.qx[L - 1 - j] = 1'b1;
                end
                if (cur.yrem >= st) begin
                    cur.yrem = cur.yrem - st;
                    cur.qy[L - 1 - j] = 1'b1;
                end
            end
            n_pipe[j] = cur;
        end
    end

    // output stage
    t_lane lst;
    logic signed [ppo_pkg::SCREEN_W-1:0] n_sx, n_sy;
    logic signed [ppo_pkg::DEPTH_W-1:0]  n_dp;
    assign lst = r_pipe[L-1];

    always_comb begin
        logic signed [ppo_pkg::SCREEN_W-1:0] mx, my;
        mx = ppo_pkg::SCREEN_W'(lst.qx);
        my = ppo_pkg::SCREEN_W'(lst.qy);
        if (lst.dep.neg_x ^ r_centre[32]) mx = -mx;
        if (lst.dep.neg_y ^ r_centre[33]) my = -my;
        n_sx = mx + ppo_pkg::SCREEN_W'({r_centre[15:0], 4'b0});
        n_sy = my + ppo_pkg::SCREEN_W'({r_centre[31:16], 4'b0});
        priority if (lst.dep.dovf) begin
            n_dp = lst.dep.dneg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else if (lst.dep.dneg) begin
            n_dp = (lst.dq > 32'h8000_0000) ? 32'sh8000_0000 : -$signed(lst.dq);
        end else begin
            n_dp = (lst.dq > 32'h7fff_ffff) ? 32'sh7fff_ffff : $signed(lst.dq);
        end
        if (lst.dep.deg) begin
            n_sx = '0;
            n_sy = '0;
            n_dp = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_m_axis_tdata <= {6'b0, lst.dep.deg, !n_dp[ppo_pkg::DEPTH_W-1] && !lst.dep.deg,
                               n_dp, n_sy, n_sx};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r_pv <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r0_v <= i_s_axis_tvalid;
            r1_v <= r0_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= r7_v;
            r_pv <= {r_pv[L-2:0], r8_v};
            r_ov <= r_pv[L-1];
        end
    end

    assign o_m_axis_tvalid = r_ov;

    // hold the pipeline while the receiver stalls
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_m_axis_tready) |=> ($stable(r_pv) && $stable(r8_v)))
        else $error("pipeline moved during stall");

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && o_m_axis_tdata[89]) |-> (o_m_axis_tdata[88:0] == '0))
        else $error("degenerate result has nonzero fields");

    a_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_m_axis_tdata[89]) |-> (o_m_axis_tdata[88] == !o_m_axis_tdata[87]))
        else $error("in_front disagrees with depth sign");
endmodule
`default_nettype wire
